### rtl/core/first_fit_block_allocator_assert.svh
// Assertion macros for the allocator RTL.
// Expects clk_i and rst_ni in the scope where the macros are used.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define FFBA_ASSERT_HOLDS(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FFBA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/ffba_pkg.sv
// Types and codes for the first-fit block allocator.
// No dependencies; imported by the allocator top level.
`timescale 1ns / 1ps

package ffba_pkg;

  localparam int unsigned ADDR_BITS = 32;
  localparam int unsigned SIZE_BITS = 27;
  localparam int unsigned HDR_BITS  = 8;
  localparam int unsigned TOTAL_W   = 9;

  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_FREE    = 2'd1;
  localparam logic [1:0] OP_REALLOC = 2'd2;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_SIZE   = 3'd1;
  localparam logic [2:0] ST_HEAP_FULL  = 3'd2;
  localparam logic [2:0] ST_TABLE_FULL = 3'd3;
  localparam logic [2:0] ST_NULL       = 3'd4;
  localparam logic [2:0] ST_UNKNOWN    = 3'd5;

  localparam logic [1:0] CFG_HEAP_LIMIT  = 2'd0;
  localparam logic [1:0] CFG_HEADER      = 2'd1;
  localparam logic [1:0] CFG_MAX_REQUEST = 2'd2;

  localparam logic [ADDR_BITS-1:0] HEAP_LIMIT_RST = 32'hFFFF_FFFF;
  localparam logic [HDR_BITS-1:0]  HEADER_RST     = 8'd32;
  localparam logic [SIZE_BITS-1:0] MAX_REQ_RST    = 27'd100000000;

  typedef struct packed {
    logic [1:0]           op;
    logic [SIZE_BITS-1:0] req_size;
    logic [ADDR_BITS-1:0] payload_addr;
  } in_word_t;

  typedef struct packed {
    logic [2:0]           status;
    logic [ADDR_BITS-1:0] result_addr;
    logic [TOTAL_W-1:0]   free_block_count;
    logic [ADDR_BITS-1:0] free_byte_total;
    logic [TOTAL_W-1:0]   block_total;
    logic [ADDR_BITS-1:0] byte_total;
  } out_word_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] start;
    logic [SIZE_BITS-1:0] size;
    logic                 free;
  } entry_t;

endpackage

### rtl/core/ffba_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ffba_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/first_fit_block_allocator.sv
// First-fit heap block allocator, top level: sequencer, counters, config registers.
// Depends on ffba_pkg, ffba_ram and first_fit_block_allocator_assert.svh.
//
// One request is taken at a time; in_stall_o stays high until its word is
// staged for output. An alloc or free walks the block table, and a realloc
// that has to move walks it twice, the block table RAM being walked one
// entry per cycle through its single read port. A bad size, or a null
// address on a free, goes straight to done without a walk. The table needs no
// clearing after reset. Configuration writes are applied at once.
`timescale 1ns / 1ps

`include "first_fit_block_allocator_assert.svh"

module first_fit_block_allocator #(
  parameter int unsigned MAX_BLOCKS = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ffba_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ffba_pkg::out_word_t out_word_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [31:0]         cfg_data_i
);

  import ffba_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_BLOCKS);
  localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_APPEND = 3'd2;
  localparam logic [2:0] S_MARK   = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0]           state_q, state_d;
  logic [ADDR_BITS-1:0] heap_limit_q;
  logic [HDR_BITS-1:0]  hdr_q;
  logic [SIZE_BITS-1:0] max_req_q;

  logic [CNT_W-1:0]     count_q, count_d;
  logic [CNT_W-1:0]     free_cnt_q, free_cnt_d;
  logic [ADDR_BITS-1:0] heap_top_q, heap_top_d;
  logic [ADDR_BITS-1:0] free_bytes_q, free_bytes_d;
  logic [ADDR_BITS-1:0] used_bytes_q, used_bytes_d;

  logic [1:0]           op_q, op_d;
  logic [SIZE_BITS-1:0] size_q, size_d;
  logic [ADDR_BITS-1:0] addr_q, addr_d;
  logic [ADDR_BITS:0]   need_q, need_d;
  logic                 lookup_q, lookup_d;
  logic                 realloc_q, realloc_d;
  logic [CNT_W-1:0]     idx_q, idx_d;
  logic                 pend_q, pend_d;
  logic [IDX_W-1:0]     pend_idx_q, pend_idx_d;
  logic [IDX_W-1:0]     k_idx_q, k_idx_d;
  entry_t               k_ent_q, k_ent_d;
  logic [2:0]           st_q, st_d;
  logic [ADDR_BITS-1:0] res_q, res_d;

  logic                 out_valid_q, out_valid_d;
  out_word_t            out_q, out_d;

  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  entry_t               ram_wdata;
  entry_t               rd_ent;
  logic [ADDR_BITS-1:0] rd_payload;
  logic                 chk_hit;
  logic                 issue;
  logic                 accept;
  logic                 bad_size;

  ffba_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_BLOCKS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (idx_q[IDX_W-1:0]),
    .rdata_o (rd_ent)
  );

  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign bad_size   = (in_word_i.req_size == '0) || (in_word_i.req_size > max_req_q);
  assign rd_payload = rd_ent.start + ADDR_BITS'(hdr_q);
  assign issue      = idx_q < count_q;
  assign chk_hit    = pend_q && (lookup_q ? (rd_payload == addr_q)
                                          : (rd_ent.free && (size_q <= rd_ent.size)));

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    free_cnt_d   = free_cnt_q;
    heap_top_d   = heap_top_q;
    free_bytes_d = free_bytes_q;
    used_bytes_d = used_bytes_q;
    op_d         = op_q;
    size_d       = size_q;
    addr_d       = addr_q;
    need_d       = need_q;
    lookup_d     = lookup_q;
    realloc_d    = realloc_q;
    idx_d        = idx_q;
    pend_d       = pend_q;
    pend_idx_d   = pend_idx_q;
    k_idx_d      = k_idx_q;
    k_ent_d      = k_ent_q;
    st_d         = st_q;
    res_d        = res_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && out_stall_i;
    ram_we       = 1'b0;
    ram_waddr    = pend_idx_q;
    ram_wdata    = rd_ent;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d      = in_word_i.op;
          size_d    = in_word_i.req_size;
          addr_d    = in_word_i.payload_addr;
          need_d    = (ADDR_BITS+1)'(heap_top_q) + (ADDR_BITS+1)'(hdr_q)
                      + (ADDR_BITS+1)'(in_word_i.req_size);
          res_d     = '0;
          st_d      = ST_OK;
          realloc_d = 1'b0;
          idx_d     = '0;
          pend_d    = 1'b0;
          priority if (in_word_i.op == OP_ALLOC) begin
            if (bad_size) begin
              st_d    = ST_BAD_SIZE;
              state_d = S_DONE;
            end else begin
              lookup_d = 1'b0;
              state_d  = S_SCAN;
            end
          end else if (in_word_i.op == OP_REALLOC) begin
            if (bad_size) begin
              st_d    = ST_BAD_SIZE;
              state_d = S_DONE;
            end else begin
              lookup_d = (in_word_i.payload_addr != '0);
              state_d  = S_SCAN;
            end
          end else begin
            // free, and the unused op code which behaves as free
            if (in_word_i.payload_addr == '0) begin
              st_d    = ST_NULL;
              state_d = S_DONE;
            end else begin
              lookup_d = 1'b1;
              state_d  = S_SCAN;
            end
          end
        end
      end

      S_SCAN: begin
        if (chk_hit) begin
          pend_d = 1'b0;
          if (lookup_q) begin
            k_idx_d = pend_idx_q;
            k_ent_d = rd_ent;
            if (op_q != OP_REALLOC) begin
              state_d = S_MARK;
            end else if (size_q <= rd_ent.size) begin
              res_d   = addr_q;
              state_d = S_DONE;
            end else begin
              // block too small: rescan for a first fit, release it afterwards
              lookup_d  = 1'b0;
              realloc_d = 1'b1;
              idx_d     = '0;
            end
          end else begin
            ram_we         = 1'b1;
            ram_wdata.free = 1'b0;
            free_cnt_d     = free_cnt_q - CNT_W'(1);
            free_bytes_d   = free_bytes_q - ADDR_BITS'(rd_ent.size);
            res_d          = rd_payload;
            state_d        = realloc_q ? S_MARK : S_DONE;
          end
        end else if (issue) begin
          pend_d     = 1'b1;
          pend_idx_d = idx_q[IDX_W-1:0];
          idx_d      = idx_q + CNT_W'(1);
        end else if (pend_q) begin
          pend_d = 1'b0;
        end else if (lookup_q) begin
          st_d    = ST_UNKNOWN;
          state_d = S_DONE;
        end else begin
          state_d = S_APPEND;
        end
      end

      S_APPEND: begin
        priority if (count_q == CNT_W'(MAX_BLOCKS)) begin
          st_d    = ST_TABLE_FULL;
          state_d = S_DONE;
        end else if (need_q > {1'b0, heap_limit_q}) begin
          st_d    = ST_HEAP_FULL;
          state_d = S_DONE;
        end else begin
          ram_we          = 1'b1;
          ram_waddr       = count_q[IDX_W-1:0];
          ram_wdata.start = heap_top_q;
          ram_wdata.size  = size_q;
          ram_wdata.free  = 1'b0;
          res_d           = heap_top_q + ADDR_BITS'(hdr_q);
          count_d         = count_q + CNT_W'(1);
          heap_top_d      = need_q[ADDR_BITS-1:0];
          used_bytes_d    = used_bytes_q + ADDR_BITS'(size_q);
          state_d         = realloc_q ? S_MARK : S_DONE;
        end
      end

      S_MARK: begin
        if (!k_ent_q.free) begin
          ram_we         = 1'b1;
          ram_waddr      = k_idx_q;
          ram_wdata      = k_ent_q;
          ram_wdata.free = 1'b1;
          free_cnt_d     = free_cnt_q + CNT_W'(1);
          free_bytes_d   = free_bytes_q + ADDR_BITS'(k_ent_q.size);
        end
        state_d = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d.status           = st_q;
          out_d.result_addr      = res_q;
          out_d.free_block_count = TOTAL_W'(free_cnt_q);
          out_d.free_byte_total  = free_bytes_q;
          out_d.block_total      = TOTAL_W'(count_q);
          out_d.byte_total       = used_bytes_q;
          out_valid_d            = 1'b1;
          state_d                = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      heap_limit_q <= HEAP_LIMIT_RST;
      hdr_q        <= HEADER_RST;
      max_req_q    <= MAX_REQ_RST;
      count_q      <= '0;
      free_cnt_q   <= '0;
      heap_top_q   <= '0;
      free_bytes_q <= '0;
      used_bytes_q <= '0;
      pend_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      free_cnt_q   <= free_cnt_d;
      heap_top_q   <= heap_top_d;
      free_bytes_q <= free_bytes_d;
      used_bytes_q <= used_bytes_d;
      pend_q       <= pend_d;
      out_valid_q  <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_HEAP_LIMIT:  heap_limit_q <= cfg_data_i;
          CFG_HEADER:      hdr_q        <= cfg_data_i[HDR_BITS-1:0];
          CFG_MAX_REQUEST: max_req_q    <= cfg_data_i[SIZE_BITS-1:0];
          default:         ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    size_q     <= size_d;
    addr_q     <= addr_d;
    need_q     <= need_d;
    lookup_q   <= lookup_d;
    realloc_q  <= realloc_d;
    idx_q      <= idx_d;
    pend_idx_q <= pend_idx_d;
    k_idx_q    <= k_idx_d;
    k_ent_q    <= k_ent_d;
    st_q       <= st_d;
    res_q      <= res_d;
    out_q      <= out_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  `FFBA_ASSERT_HOLDS(a_free_le_total, 1'b1, free_cnt_q <= count_q, "free blocks exceed table")
  `FFBA_ASSERT_HOLDS(a_total_le_max, 1'b1, count_q <= CNT_W'(MAX_BLOCKS), "table overrun")
  `FFBA_ASSERT_HOLDS(a_scan_in_range, state_q == S_SCAN, idx_q <= count_q, "scan past table")
  `FFBA_ASSERT_NEXT(a_accept_busy, in_valid_i && !in_stall_o, state_q != S_IDLE,
                    "accepted word not started")
  `FFBA_ASSERT_NEXT(a_done_loads, state_q == S_DONE && (!out_valid_q || !out_stall_i),
                    out_valid_q && state_q == S_IDLE, "result word not staged")

endmodule
